/* rtl/range_lru_cache_unit_assert.svh */
// ----------------------------------------------------------------------------
// range_lru_cache_unit_assert.svh
// Assertion macros shared by the range cache RTL.
// ----------------------------------------------------------------------------
`ifndef RANGE_LRU_CACHE_UNIT_ASSERT_SVH
`define RANGE_LRU_CACHE_UNIT_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define RLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the next.
`define RLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/rlc_pkg.sv */
// ----------------------------------------------------------------------------
// rlc_pkg
// Types and codes for the range LRU cache.
// ----------------------------------------------------------------------------
package rlc_pkg;

  localparam int unsigned RLC_CAPACITY = 64;
  localparam logic [6:0]  RLC_MAX_RESET = 7'd64;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_FLUSH  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    STS_INSERTED  = 3'd0,
    STS_PRESENT   = 3'd1,
    STS_HIT       = 3'd2,
    STS_MISS      = 3'd3,
    STS_REMOVED   = 3'd4,
    STS_NOT_FOUND = 3'd5,
    STS_FLUSHED   = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_UPDATE,
    S_CLEAR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] addr;
    logic [31:0] range_size;
    logic [15:0] name_tag;
    logic [15:0] file_tag;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] found_name;
    logic        file_match;
    logic        evicted;
    logic [6:0]  occupancy;
  } out_item_t;

endpackage

/* rtl/range_lru_cache_unit.sv */
// ----------------------------------------------------------------------------
// range_lru_cache_unit
// Fully associative range table in one memory, kept in LRU order by rank.
// ----------------------------------------------------------------------------
// Add miss, lookup hit and remove hit sweep all slots once to scan and once to
// update; add hit, lookup miss and remove miss sweep only to scan; flush scans
// and then clears every slot. out_valid strobes when an item is done, and the
// next item is accepted in the cycle after the strobe. The unit takes no new
// item while busy. After reset the unit clears every memory slot with busy high.
// Results are not held off by the receiver; out_valid lasts one cycle.
module range_lru_cache_unit
  import rlc_pkg::*;
#(
  parameter int unsigned CAPACITY = RLC_CAPACITY
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_item_t   in_data,
  output logic       out_valid,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned LW = (CW > 7) ? CW : 7;

  typedef struct packed {
    logic          valid;
    logic [IW-1:0] age;
    logic [63:0]   base_addr;
    logic [31:0]   length;
    logic [15:0]   name;
    logic [15:0]   file;
  } slot_t;

  slot_t mem [CAPACITY];
  slot_t rd_q;
  slot_t wr_d;
  logic  wr_en;
  logic [IW-1:0] wr_a;

  state_t state_r, state_nxt;
  in_item_t  item_r;
  out_item_t res_r;
  logic [6:0]    max_r;
  logic [CW-1:0] count_r;
  logic [IW:0]   cnt_r;
  logic          pvld_r;
  logic [IW-1:0] pidx_r;

  logic          hit_found_r, old_found_r, free_found_r;
  logic [IW-1:0] hit_idx_r, old_idx_r, free_idx_r, hit_age_r, old_age_r;
  logic [15:0]   hit_name_r, hit_file_r;
  logic          evict_r, ins_ok_r;
  logic [IW-1:0] ins_idx_r;

  logic          sweep_done, issue;
  logic [63:0]   diff;
  logic          rd_hit;

  // decision signals
  logic [6:0]    lim7;
  logic [LW-1:0] lim_w;
  logic          d_evict, d_ins_ok;
  logic [IW-1:0] d_ins;
  logic [CW-1:0] d_count;
  out_item_t     d_res;
  logic          d_update;

  assign cfg_ready  = 1'b1;
  assign sweep_done = (cnt_r == (IW+1)'(CAPACITY)) && !pvld_r;
  assign issue      = (cnt_r != (IW+1)'(CAPACITY));
  assign diff       = item_r.addr - rd_q.base_addr;
  assign rd_hit     = rd_q.valid && (item_r.addr >= rd_q.base_addr) &&
                      (diff < {32'b0, rd_q.length});

  always_comb begin
    lim7 = (max_r == 7'd0) ? 7'd1 : max_r;
    lim_w = (LW'(lim7) > LW'(CAPACITY)) ? LW'(CAPACITY) : LW'(lim7);
    d_evict = (LW'(count_r) >= lim_w) && old_found_r;
    d_ins_ok = free_found_r || d_evict;
    if (d_evict && (!free_found_r || old_idx_r < free_idx_r)) begin
      d_ins = old_idx_r;
    end else begin
      d_ins = free_idx_r;
    end
    d_count = count_r;
    d_update = 1'b0;
    d_res = '0;
    case (kind_t'(item_r.kind))
      KIND_ADD: begin
        if (hit_found_r) begin
          d_res.status = STS_PRESENT;
        end else begin
          d_res.status = STS_INSERTED;
          d_res.evicted = d_evict;
          d_count = count_r - CW'(d_evict) + CW'(d_ins_ok);
          d_update = 1'b1;
        end
      end
      KIND_LOOKUP: begin
        if (hit_found_r) begin
          d_res.status = STS_HIT;
          d_res.found_name = hit_name_r;
          d_res.file_match = (hit_file_r == item_r.file_tag);
          d_update = 1'b1;
        end else begin
          d_res.status = STS_MISS;
        end
      end
      KIND_REMOVE: begin
        if (hit_found_r) begin
          d_res.status = STS_REMOVED;
          d_count = count_r - CW'(1);
          d_update = 1'b1;
        end else begin
          d_res.status = STS_NOT_FOUND;
        end
      end
      default: begin
        d_res.status = STS_FLUSHED;
        d_count = '0;
      end
    endcase
    d_res.occupancy = 7'(d_count);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT:   if (!issue) state_nxt = S_IDLE;
      S_IDLE:   if (start) state_nxt = S_SCAN;
      S_SCAN:   if (sweep_done) state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (kind_t'(item_r.kind) == KIND_FLUSH) begin
          state_nxt = S_CLEAR;
        end else if (d_update) begin
          state_nxt = S_UPDATE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_UPDATE: if (sweep_done) state_nxt = S_DONE;
      S_CLEAR:  if (!issue) state_nxt = S_DONE;
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_INIT;
    endcase
  end

  // outputs and memory write port
  always_comb begin
    busy = (state_r != S_IDLE);
    out_valid = (state_r == S_DONE);
    out_data = res_r;
    wr_en = 1'b0;
    wr_a = pidx_r;
    wr_d = rd_q;
    unique case (state_r)
      S_INIT, S_CLEAR: begin
        wr_en = issue;
        wr_a = cnt_r[IW-1:0];
        wr_d = '0;
      end
      S_UPDATE: begin
        wr_en = pvld_r;
        case (kind_t'(item_r.kind))
          KIND_ADD: begin
            if (ins_ok_r && pidx_r == ins_idx_r) begin
              wr_d.valid = 1'b1;
              wr_d.age = '0;
              wr_d.base_addr = item_r.addr;
              wr_d.length = item_r.range_size;
              wr_d.name = item_r.name_tag;
              wr_d.file = item_r.file_tag;
            end else if (evict_r && pidx_r == old_idx_r) begin
              wr_d.valid = 1'b0;
              wr_d.age = '0;
            end else if (rd_q.valid) begin
              wr_d.age = rd_q.age - IW'(evict_r && rd_q.age > old_age_r) + IW'(ins_ok_r);
            end
          end
          KIND_LOOKUP: begin
            if (pidx_r == hit_idx_r) begin
              wr_d.age = '0;
            end else if (rd_q.valid && rd_q.age < hit_age_r) begin
              wr_d.age = rd_q.age + IW'(1);
            end
          end
          default: begin
            if (pidx_r == hit_idx_r) begin
              wr_d.valid = 1'b0;
              wr_d.age = '0;
            end else if (rd_q.valid && rd_q.age > hit_age_r) begin
              wr_d.age = rd_q.age - IW'(1);
            end
          end
        endcase
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_a] <= wr_d;
    end
    rd_q <= mem[cnt_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      max_r   <= RLC_MAX_RESET;
      count_r <= '0;
      cnt_r   <= '0;
      pvld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        max_r <= cfg_data;
      end
      pvld_r <= 1'b0;
      unique case (state_r)
        S_INIT, S_CLEAR: if (issue) cnt_r <= cnt_r + 1'b1;
        S_SCAN, S_UPDATE: begin
          if (issue) begin
            cnt_r  <= cnt_r + 1'b1;
            pvld_r <= 1'b1;
          end
        end
        S_DECIDE: begin
          cnt_r   <= '0;
          count_r <= d_count;
        end
        default: cnt_r <= '0;
      endcase
    end
  end

  // payload and scan results
  always_ff @(posedge clk) begin
    pidx_r <= cnt_r[IW-1:0];
    if (state_r == S_IDLE) begin
      item_r       <= in_data;
      hit_found_r  <= 1'b0;
      old_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end
    if (state_r == S_SCAN && pvld_r) begin
      // keep the lowest matching slot
      if (rd_hit && !hit_found_r) begin
        hit_found_r <= 1'b1;
        hit_idx_r   <= pidx_r;
        hit_age_r   <= rd_q.age;
        hit_name_r  <= rd_q.name;
        hit_file_r  <= rd_q.file;
      end
      if (rd_q.valid && (!old_found_r || rd_q.age > old_age_r)) begin
        old_found_r <= 1'b1;
        old_idx_r   <= pidx_r;
        old_age_r   <= rd_q.age;
      end
      if (!rd_q.valid && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= pidx_r;
      end
    end
    if (state_r == S_DECIDE) begin
      res_r     <= d_res;
      evict_r   <= d_evict;
      ins_ok_r  <= d_ins_ok;
      ins_idx_r <= d_ins;
    end
  end

`include "range_lru_cache_unit_assert.svh"

  `RLC_ASSERT_NEXT(a_strobe_once, out_valid, !out_valid, "result strobe longer than one cycle")
  `RLC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `RLC_ASSERT(a_count_cap, count_r <= CW'(CAPACITY), "entry count above capacity")
  `RLC_ASSERT(a_evict_add, !out_valid || !out_data.evicted || out_data.status == STS_INSERTED, "eviction outside insert")

endmodule
